[rtl/trt_pkg.sv]
// Package: shared types, sizes and helpers of the tagged request/response tracker.
package trt_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PENDING_SLOTS = 16;
    localparam int PAYLOAD_BITS  = 64;
    localparam int ID_BITS       = 32;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SPTR_W = $clog2(PENDING_SLOTS);
    localparam int SCNT_W = $clog2(PENDING_SLOTS + 1);

    typedef logic [QPTR_W-1:0]       qptr_t;
    typedef logic [QCNT_W-1:0]       qcnt_t;
    typedef logic [SPTR_W-1:0]       sptr_t;
    typedef logic [SCNT_W-1:0]       scnt_t;
    typedef logic [PAYLOAD_BITS-1:0] pay_t;
    typedef logic [ID_BITS-1:0]      id_t;
    typedef logic [PENDING_SLOTS-1:0] svec_t;

    typedef enum logic [1:0] {
        ACT_SEND_REQ = 2'd0,
        ACT_RECV_REQ = 2'd1,
        ACT_SEND_RSP = 2'd2,
        ACT_GET_RSP  = 2'd3
    } action_t;

    typedef struct packed {
        logic capture;
        logic search;
        logic exec;
        logic go;
        logic enq;
        logic deq;
        logic store;
        logic free;
        logic skip;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    req_full;
        logic    req_empty;
        logic    res_full;
        logic    found;
    } stat_t;

    function automatic qptr_t q_inc(input qptr_t p);
        q_inc = (p == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + qptr_t'(1);
    endfunction

    function automatic sptr_t s_inc(input sptr_t p);
        s_inc = (p == sptr_t'(PENDING_SLOTS - 1)) ? '0 : p + sptr_t'(1);
    endfunction

    // first set bit at or after start, wrapping round the table
    function automatic sptr_t first_from(input svec_t bits, input sptr_t start);
        sptr_t           pick;
        logic [SPTR_W:0] sum;
        pick = start;
        for (int k = PENDING_SLOTS - 1; k >= 0; k--)
        begin
            sum = {1'b0, start} + (SPTR_W + 1)'(k);
            if (sum >= (SPTR_W + 1)'(PENDING_SLOTS))
            begin
                sum = sum - (SPTR_W + 1)'(PENDING_SLOTS);
            end
            if (bits[sum[SPTR_W-1:0]])
            begin
                pick = sum[SPTR_W-1:0];
            end
        end
        first_from = pick;
    endfunction

endpackage

[rtl/trt_ctrl.sv]
// Controller: sequencing state machine, run flag and accept decisions.
module trt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          cfg_valid,
    input  logic          cfg_data,
    input  trt_pkg::stat_t stat,
    output logic          busy,
    output logic          done,
    output logic          cfg_ready,
    output trt_pkg::cmd_t cmd
);
    import trt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_EXEC   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   running_reg;
    logic   freed_reg;
    logic   go;

    always_comb
    begin
        case (stat.action)
            ACT_SEND_REQ: go = running_reg && !stat.req_full;
            ACT_RECV_REQ: go = running_reg && !stat.req_empty;
            ACT_SEND_RSP: go = running_reg && !stat.res_full;
            ACT_GET_RSP:  go = stat.found;
            default:      go = 1'b0;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = start ? ST_SEARCH : ST_IDLE;
            ST_SEARCH: state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.capture = (state_reg == ST_IDLE) && start;
        cmd.search  = (state_reg == ST_SEARCH);
        cmd.exec    = (state_reg == ST_EXEC);
        if (state_reg == ST_EXEC)
        begin
            cmd.go    = go;
            cmd.enq   = go && (stat.action == ACT_SEND_REQ);
            cmd.deq   = go && (stat.action == ACT_RECV_REQ);
            cmd.store = go && (stat.action == ACT_SEND_RSP);
            cmd.free  = go && (stat.action == ACT_GET_RSP);
        end
        cmd.skip = (state_reg == ST_DONE) && freed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            running_reg <= 1'b1;
            freed_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                running_reg <= cfg_data;
            end
            if (state_reg == ST_EXEC)
            begin
                freed_reg <= cmd.free;
            end
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign cfg_ready = (state_reg == ST_IDLE);

endmodule

[rtl/trt_dp.sv]
// Datapath: request FIFO, response slot table, id counter and result registers.
module trt_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  trt_pkg::cmd_t         cmd,
    input  logic [1:0]            action,
    input  trt_pkg::pay_t         payload,
    input  trt_pkg::id_t          resp_id,
    output trt_pkg::stat_t        stat,
    output logic                  ok,
    output trt_pkg::id_t          id_out,
    output trt_pkg::pay_t         payload_out,
    output trt_pkg::qcnt_t        queued_requests,
    output trt_pkg::scnt_t        pending_responses
);
    import trt_pkg::*;

    pay_t  req_pay_mem [QUEUE_DEPTH];
    id_t   req_id_mem  [QUEUE_DEPTH];
    pay_t  slot_pay_mem [PENDING_SLOTS];
    id_t   slot_id_reg [PENDING_SLOTS];

    action_t action_reg;
    pay_t    pay_reg;
    id_t     rid_reg;

    qptr_t req_head_reg, req_tail_reg;
    qcnt_t req_count_reg;
    id_t   next_id_reg;
    svec_t slot_valid_reg;
    sptr_t res_head_reg, res_tail_reg;
    scnt_t res_count_reg;

    pay_t  req_rd_pay_reg;
    id_t   req_rd_id_reg;
    pay_t  slot_rd_reg;
    sptr_t free_idx_reg, match_idx_reg;
    logic  found_reg;

    logic  ok_reg;
    id_t   id_out_reg;
    pay_t  res_pay_reg;
    logic  slot_sel_reg;

    svec_t match_vec;
    id_t   id_inc;

    always_comb
    begin
        for (int i = 0; i < PENDING_SLOTS; i++)
        begin
            match_vec[i] = slot_valid_reg[i] && (slot_id_reg[i] == rid_reg);
        end
    end

    assign id_inc = next_id_reg + id_t'(1);

    // input capture and search results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action_t'(action);
            pay_reg    <= payload;
            rid_reg    <= resp_id;
        end
        if (cmd.search)
        begin
            free_idx_reg  <= first_from(~slot_valid_reg, res_tail_reg);
            match_idx_reg <= first_from(match_vec, res_head_reg);
            found_reg     <= |match_vec;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.enq)
        begin
            req_pay_mem[req_tail_reg] <= pay_reg;
            req_id_mem[req_tail_reg]  <= next_id_reg;
        end
        req_rd_pay_reg <= req_pay_mem[req_head_reg];
        req_rd_id_reg  <= req_id_mem[req_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            slot_pay_mem[free_idx_reg] <= pay_reg;
            slot_id_reg[free_idx_reg]  <= rid_reg;
        end
        slot_rd_reg <= slot_pay_mem[match_idx_reg];
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg       <= cmd.go;
            slot_sel_reg <= cmd.free;
            res_pay_reg  <= cmd.deq ? req_rd_pay_reg : '0;
            if (cmd.enq)
            begin
                id_out_reg <= next_id_reg;
            end
            else if (cmd.deq)
            begin
                id_out_reg <= req_rd_id_reg;
            end
            else if (cmd.store || cmd.free)
            begin
                id_out_reg <= rid_reg;
            end
            else
            begin
                id_out_reg <= '0;
            end
        end
    end

    // pointers, counts and slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_head_reg   <= '0;
            req_tail_reg   <= '0;
            req_count_reg  <= '0;
            next_id_reg    <= id_t'(1);
            slot_valid_reg <= '0;
            res_head_reg   <= '0;
            res_tail_reg   <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            if (cmd.enq)
            begin
                req_tail_reg  <= q_inc(req_tail_reg);
                req_count_reg <= req_count_reg + qcnt_t'(1);
                next_id_reg   <= (id_inc == '0) ? id_t'(1) : id_inc;
            end
            if (cmd.deq)
            begin
                req_head_reg  <= q_inc(req_head_reg);
                req_count_reg <= req_count_reg - qcnt_t'(1);
            end
            if (cmd.store)
            begin
                slot_valid_reg[free_idx_reg] <= 1'b1;
                res_count_reg <= res_count_reg + scnt_t'(1);
                res_tail_reg  <= s_inc(res_tail_reg);
            end
            if (cmd.free)
            begin
                slot_valid_reg[match_idx_reg] <= 1'b0;
                res_count_reg <= res_count_reg - scnt_t'(1);
            end
            if (cmd.skip && (res_count_reg != '0))
            begin
                res_head_reg <= first_from(slot_valid_reg, res_head_reg);
            end
        end
    end

    assign stat.action    = action_reg;
    assign stat.req_full  = (req_count_reg == qcnt_t'(QUEUE_DEPTH));
    assign stat.req_empty = (req_count_reg == '0);
    assign stat.res_full  = (res_count_reg == scnt_t'(PENDING_SLOTS));
    assign stat.found     = found_reg;

    assign ok                = ok_reg;
    assign id_out            = id_out_reg;
    assign payload_out       = slot_sel_reg ? slot_rd_reg : res_pay_reg;
    assign queued_requests   = req_count_reg;
    assign pending_responses = res_count_reg;

endmodule

[rtl/tagged_request_response_tracker.sv]
// Top level: tagged request/response tracker, controller plus datapath.
//
// Use: drive action, payload and resp_id and raise start while busy is low;
// the request is taken at that edge and busy rises. Actions: send request
// (queued with a fresh nonzero id), receive the oldest request, send a response
// into the slot table, get a response by id. After the slot search and update
// states, done is high for one cycle with ok, id_out, payload_out and
// the occupancy counts; the receiver must take them then, it cannot stall.
// busy falls with done; a request passes through capture, slot search,
// update and result. The slot search compares all slots in parallel from flops;
// the FIFO and response payload stores are memories with a registered read.
// The run flag is written over the cfg channel (cfg_valid, cfg_ready, cfg_data)
// while idle; with it clear, send request, receive request and send response fail.
// Reset empties the FIFO and slot table, sets the next id to one and sets the
// run flag; no clearing pass is needed, so a request may start straight after.
module tagged_request_response_tracker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             action,
    input  trt_pkg::pay_t          payload,
    input  trt_pkg::id_t           resp_id,
    output logic                   done,
    output logic                   ok,
    output trt_pkg::id_t           id_out,
    output trt_pkg::pay_t          payload_out,
    output trt_pkg::qcnt_t         queued_requests,
    output trt_pkg::scnt_t         pending_responses,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);
    import trt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    trt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .busy      (busy),
        .done      (done),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    trt_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .action            (action),
        .payload           (payload),
        .resp_id           (resp_id),
        .stat              (stat),
        .ok                (ok),
        .id_out            (id_out),
        .payload_out       (payload_out),
        .queued_requests   (queued_requests),
        .pending_responses (pending_responses)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result not delivered three cycles after request");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (busy && !cfg_ready))
        else $error("result strobe outside a busy window");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (queued_requests <= qcnt_t'(QUEUE_DEPTH))
        && (pending_responses <= scnt_t'(PENDING_SLOTS)))
        else $error("occupancy beyond capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> ((id_out == '0) && (payload_out == '0)))
        else $error("failed request returned data");

endmodule

[tb/tb_tagged_request_response_tracker.sv]
// Self-checking testbench for the tagged request/response tracker.
`timescale 1ns / 1ps

module tb_tagged_request_response_tracker;
    import trt_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic  ok;
        id_t   id;
        pay_t  pay;
        qcnt_t queued;
        scnt_t pending;
    } outcome_t;

    class tracker_scoreboard;
        pay_t     fifo_pay [QUEUE_DEPTH];
        id_t      fifo_tag [QUEUE_DEPTH];
        qptr_t    fifo_rd;
        qptr_t    fifo_wr;
        qcnt_t    fifo_fill;
        id_t      id_next;
        svec_t    slot_live;
        id_t      slot_tag [PENDING_SLOTS];
        pay_t     slot_data [PENDING_SLOTS];
        sptr_t    slot_rd;
        sptr_t    slot_wr;
        scnt_t    slot_fill;
        bit       run_flag;
        outcome_t awaited [$];
        int       mismatches;

        function new();
            fifo_rd    = '0;
            fifo_wr    = '0;
            fifo_fill  = '0;
            id_next    = id_t'(1);
            slot_live  = '0;
            slot_rd    = '0;
            slot_wr    = '0;
            slot_fill  = '0;
            run_flag   = 1'b1;
            mismatches = 0;
        endfunction

        function qptr_t fifo_after(qptr_t p);
            return qptr_t'((int'(p) + 1) % QUEUE_DEPTH);
        endfunction

        function sptr_t slot_after(sptr_t p);
            return sptr_t'((int'(p) + 1) % PENDING_SLOTS);
        endfunction

        function void set_running(bit v);
            run_flag = v;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // random id currently held in the table, or any id if the table is empty
        function id_t stored_tag();
            int n;
            if (slot_fill == 0)
            begin
                return id_t'($urandom);
            end
            n = $urandom_range(0, PENDING_SLOTS - 1);
            while (!slot_live[n])
            begin
                n = (n + 1) % PENDING_SLOTS;
            end
            return slot_tag[n];
        endfunction

        function void note_request(action_t act, pay_t pay, id_t tag);
            outcome_t o;
            sptr_t    idx;
            bit       hit;
            o = '0;
            case (act)
                ACT_SEND_REQ:
                begin
                    if (run_flag && fifo_fill < QUEUE_DEPTH)
                    begin
                        fifo_pay[fifo_wr] = pay;
                        fifo_tag[fifo_wr] = id_next;
                        fifo_wr   = fifo_after(fifo_wr);
                        fifo_fill = fifo_fill + 1'b1;
                        o.ok      = 1'b1;
                        o.id      = id_next;
                        id_next   = id_next + 1'b1;
                        if (id_next == '0)
                        begin
                            id_next = id_t'(1);
                        end
                    end
                end
                ACT_RECV_REQ:
                begin
                    if (run_flag && fifo_fill != 0)
                    begin
                        o.ok      = 1'b1;
                        o.id      = fifo_tag[fifo_rd];
                        o.pay     = fifo_pay[fifo_rd];
                        fifo_rd   = fifo_after(fifo_rd);
                        fifo_fill = fifo_fill - 1'b1;
                    end
                end
                ACT_SEND_RSP:
                begin
                    if (run_flag && slot_fill < PENDING_SLOTS)
                    begin
                        idx = slot_wr;
                        while (slot_live[idx])
                        begin
                            idx = slot_after(idx);
                        end
                        slot_live[idx] = 1'b1;
                        slot_tag[idx]  = tag;
                        slot_data[idx] = pay;
                        slot_fill      = slot_fill + 1'b1;
                        slot_wr        = slot_after(slot_wr);
                        o.ok           = 1'b1;
                        o.id           = tag;
                    end
                end
                default:
                begin
                    idx = slot_rd;
                    hit = 1'b0;
                    for (int k = 0; k < PENDING_SLOTS && !hit; k++)
                    begin
                        if (slot_live[idx] && slot_tag[idx] == tag)
                            hit = 1'b1;
                        else
                            idx = slot_after(idx);
                    end
                    if (hit)
                    begin
                        o.ok           = 1'b1;
                        o.id           = tag;
                        o.pay          = slot_data[idx];
                        slot_live[idx] = 1'b0;
                        slot_fill      = slot_fill - 1'b1;
                        while (slot_fill != 0 && !slot_live[slot_rd])
                        begin
                            slot_rd = slot_after(slot_rd);
                        end
                    end
                end
            endcase
            o.queued  = fifo_fill;
            o.pending = slot_fill;
            awaited.push_back(o);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with no request outstanding: expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("ok", 64'(want.ok), 64'(got.ok));
            compare_field("id_out", 64'(want.id), 64'(got.id));
            compare_field("payload_out", 64'(want.pay), 64'(got.pay));
            compare_field("queued_requests", 64'(want.queued), 64'(got.queued));
            compare_field("pending_responses", 64'(want.pending), 64'(got.pending));
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    logic [1:0] action;
    pay_t  payload;
    id_t   resp_id;
    logic  done;
    logic  ok;
    id_t   id_out;
    pay_t  payload_out;
    qcnt_t queued_requests;
    scnt_t pending_responses;
    logic  cfg_valid;
    logic  cfg_ready;
    logic  cfg_data;

    tracker_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int          burst_left  = 0;

    tagged_request_response_tracker i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .action            (action),
        .payload           (payload),
        .resp_id           (resp_id),
        .done              (done),
        .ok                (ok),
        .id_out            (id_out),
        .payload_out       (payload_out),
        .queued_requests   (queued_requests),
        .pending_responses (pending_responses),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            sb.check_result(outcome_t'({ok, id_out, payload_out,
                                        queued_requests, pending_responses}));
        end
    end

    task automatic issue(action_t act, pay_t pay, id_t tag);
        start   <= 1'b1;
        action  <= act;
        payload <= pay;
        resp_id <= tag;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_request(act, pay, tag);
    endtask

    // only called straight after a request has been taken
    task automatic drain();
        start <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_run(bit v);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_running(v);
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // mode 0 balanced, 1 filling, 2 draining
    task automatic random_item(int mode);
        int      r;
        int      t0;
        int      t1;
        int      t2;
        action_t act;
        id_t     tag;
        pay_t    pay;
        pay = {$urandom, $urandom};
        tag = id_t'($urandom);
        t0 = (mode == 1) ? 40 : (mode == 2) ? 10 : 25;
        t1 = 50;
        t2 = (mode == 1) ? 85 : (mode == 2) ? 60 : 75;
        r = $urandom_range(0, 99);
        if (r < t0)
            act = ACT_SEND_REQ;
        else if (r < t1)
            act = ACT_RECV_REQ;
        else if (r < t2)
            act = ACT_SEND_RSP;
        else
            act = ACT_GET_RSP;
        r = $urandom_range(0, 9);
        if (act == ACT_SEND_RSP)
        begin
            if (r < 4)
                tag = sb.stored_tag();
            else if (r < 7)
                tag = id_t'($urandom_range(1, 8));
        end
        else if (act == ACT_GET_RSP)
        begin
            if (r < 8)
                tag = sb.stored_tag();
            else if (r < 9)
                tag = id_t'($urandom_range(0, 8));
        end
        issue(act, pay, tag);
    endtask

    initial
    begin
        int  sent;
        int  phase;
        int  n;
        int  pause_at;
        bit  run;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        action     <= ACT_SEND_REQ;
        payload    <= '0;
        resp_id    <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty structures, extremes of payload and id, duplicate ids
        issue(ACT_GET_RSP,  '0, '0);
        issue(ACT_RECV_REQ, '0, '0);
        issue(ACT_SEND_REQ, '1, '0);
        issue(ACT_SEND_REQ, '0, '1);
        issue(ACT_RECV_REQ, '0, '0);
        issue(ACT_RECV_REQ, '1, '1);
        issue(ACT_SEND_RSP, '1, '0);
        issue(ACT_SEND_RSP, '0, '1);
        issue(ACT_SEND_RSP, 64'h0123_4567_89ab_cdef, id_t'(5));
        issue(ACT_SEND_RSP, 64'hfedc_ba98_7654_3210, id_t'(5));
        issue(ACT_GET_RSP,  '0, id_t'(5));
        issue(ACT_GET_RSP,  '0, '0);
        issue(ACT_GET_RSP,  '0, '0);
        issue(ACT_GET_RSP,  '0, id_t'(5));
        issue(ACT_GET_RSP,  '0, '1);
        issue(ACT_GET_RSP,  '0, id_t'(32'h1234_5678));
        issue(ACT_SEND_REQ, 64'h5555_aaaa_5555_aaaa, id_t'(9));
        issue(ACT_SEND_RSP, 64'haaaa_5555_aaaa_5555, id_t'(9));

        // stopped: everything but lookup refused
        write_run(1'b0);
        issue(ACT_SEND_REQ, '1, '1);
        issue(ACT_RECV_REQ, '0, '0);
        issue(ACT_SEND_RSP, '1, '1);
        issue(ACT_GET_RSP,  '0, id_t'(9));
        write_run(1'b1);
        issue(ACT_RECV_REQ, '0, '0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            run = (phase % 4 == 3) ? 1'b0 : 1'b1;
            write_run(run);
            n = run ? $urandom_range(80, 160) : $urandom_range(20, 40);
            pause_at = $urandom_range(1, n - 2);
            for (int j = 0; j < n; j++)
            begin
                pace();
                random_item(phase % 3);
                if (j == pause_at)
                begin
                    drain();
                end
                sent++;
            end
            phase++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/trt_pkg.sv
rtl/trt_ctrl.sv
rtl/trt_dp.sv
rtl/tagged_request_response_tracker.sv
tb/tb_tagged_request_response_tracker.sv
